/* src/atci_pkg.sv */
// ----------------------------------------------------------------------------
// atci_pkg: shared types and constants of the text console interpreter
// Command codes, parser modes, the result beat and the parser state record,
// plus the clamping helpers used to build drawing commands.
// ----------------------------------------------------------------------------
package atci_pkg;

  // Signed working width for coordinate arithmetic (16-bit argument plus
  // cursor plus carry).
  localparam int SW = 18;
  typedef logic signed [SW-1:0] sval_t;

  // Result slots per character and a count that can hold the depth itself.
  localparam int RES_DEPTH = 3;
  typedef logic [1:0] res_cnt_t;

  typedef enum logic [3:0] {
    CMD_GLYPH     = 4'd0,
    CMD_CLEAR     = 4'd1,
    CMD_DEL_CHARS = 4'd2,
    CMD_INS_CHARS = 4'd3,
    CMD_DEL_LINES = 4'd4,
    CMD_INS_LINES = 4'd5,
    CMD_INVERT    = 4'd6,
    CMD_BELL      = 4'd7,
    CMD_FONT_INIT = 4'd8
  } cmd_code_t;

  typedef enum logic [2:0] {
    MODE_ALPHA = 3'b001,
    MODE_CSI   = 3'b010,
    MODE_SKIP  = 3'b100
  } mode_t;

  // Control characters
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_HT       = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUERY    = 8'h3F;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  // CSI final characters
  localparam logic [7:0] CSI_ICH    = 8'h40;  // '@' insert chars
  localparam logic [7:0] CSI_CUU    = 8'h41;  // 'A' cursor up
  localparam logic [7:0] CSI_CUD    = 8'h42;  // 'B' cursor down
  localparam logic [7:0] CSI_CUF    = 8'h43;  // 'C' cursor forward
  localparam logic [7:0] CSI_CUB    = 8'h44;  // 'D' cursor back
  localparam logic [7:0] CSI_CNL    = 8'h45;  // 'E' next line
  localparam logic [7:0] CSI_CUP    = 8'h48;  // 'H' cursor position
  localparam logic [7:0] CSI_ED     = 8'h4A;  // 'J' erase display
  localparam logic [7:0] CSI_EL     = 8'h4B;  // 'K' erase line
  localparam logic [7:0] CSI_IL     = 8'h4C;  // 'L' insert lines
  localparam logic [7:0] CSI_DL     = 8'h4D;  // 'M' delete lines
  localparam logic [7:0] CSI_DCH    = 8'h50;  // 'P' delete chars
  localparam logic [7:0] CSI_HVP    = 8'h66;  // 'f' cursor position
  localparam logic [7:0] CSI_SGR    = 8'h6D;  // 'm' reverse video
  localparam logic [7:0] CSI_POS    = 8'h70;  // 'p' normal screen
  localparam logic [7:0] CSI_NEG    = 8'h71;  // 'q' reversed screen
  localparam logic [7:0] CSI_SCROLL = 8'h72;  // 'r' scroll count
  localparam logic [7:0] CSI_FONT   = 8'h73;  // 's' font init

  typedef struct packed {
    cmd_code_t  command;
    logic [6:0] col_from;
    logic [7:0] col_to;
    logic [5:0] row_from;
    logic [6:0] row_to;
    logic [6:0] glyph_index;
    logic       reverse_video;
  } cmd_t;

  typedef struct packed {
    mode_t       mode;
    logic        esc;
    logic [6:0]  col;
    logic [5:0]  row;
    logic [15:0] arg_cur;
    logic [15:0] arg_first;
    logic [15:0] scroll;
    logic        char_rev;
    logic        scr_rev;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:      MODE_ALPHA,
    esc:       1'b0,
    col:       7'd0,
    row:       6'd0,
    arg_cur:   16'h0000,
    arg_first: 16'hFFFF,
    scroll:    16'h0001,
    char_rev:  1'b0,
    scr_rev:   1'b0
  };

  // Clamp a signed value into 0..hi
  function automatic sval_t clamp(sval_t v, sval_t hi);
    if (v[SW-1]) begin
      return '0;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Build one result beat, saturating each coordinate and the glyph index to its range
  function automatic cmd_t make_cmd(cmd_code_t code, sval_t cf, sval_t ct, sval_t rf,
                                    sval_t rt, sval_t gi, logic rv);
    cmd_t r;
    r.command       = code;
    r.col_from      = 7'(clamp(cf, sval_t'(127)));
    r.col_to        = 8'(clamp(ct, sval_t'(255)));
    r.row_from      = 6'(clamp(rf, sval_t'(63)));
    r.row_to        = 7'(clamp(rt, sval_t'(127)));
    r.glyph_index   = 7'(clamp(gi, sval_t'(127)));
    r.reverse_video = rv;
    return r;
  endfunction

endpackage

/* src/atci_step.sv */
// ----------------------------------------------------------------------------
// atci_step: one-character parser step
// Combinational next state and up to RES_DEPTH drawing commands for the
// registered character and the current parser state.
// ----------------------------------------------------------------------------
module atci_step #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 34
) (
  input  atci_pkg::state_t                          st,
  input  logic [7:0]                                ch,
  output atci_pkg::state_t                          nxt,
  output atci_pkg::cmd_t [atci_pkg::RES_DEPTH-1:0]  cmds,
  output atci_pkg::res_cnt_t                        cnt
);
  import atci_pkg::*;

  localparam sval_t COL_MAX = sval_t'(SCREEN_COLS - 1);
  localparam sval_t ROW_MAX = sval_t'(SCREEN_ROWS - 1);
  localparam sval_t COLS_S  = sval_t'(SCREEN_COLS);
  localparam sval_t ROWS_S  = sval_t'(SCREEN_ROWS);
  localparam sval_t ONE_S   = sval_t'(1);

  logic [7:0]        c;
  sval_t             ax, ay, init, ac, first;
  logic signed [11:0] acc;
  sval_t             lfs_raw, lfs;
  logic [6:0]        feed_col_in, feed_col;
  logic [5:0]        feed_row;
  logic              feed_has;
  cmd_t              feed_cmd;
  res_cnt_t          n;

  // Escape-question is handled as a DEL through the normal path
  assign c = (st.esc && ch == CH_QUERY) ? CH_DEL : ch;

  assign ax    = sval_t'(st.col);
  assign ay    = sval_t'(st.row);
  assign init  = sval_t'($signed(st.arg_cur));
  assign ac    = (init == '0) ? ONE_S : init;
  assign first = sval_t'($signed(st.arg_first));

  // Digit accumulate on the low byte of the argument taken as signed
  assign acc = $signed({{4{st.arg_cur[7]}}, st.arg_cur[7:0]}) * 12'sd10
             + $signed({8'b0, c[3:0]});

  // Line feed: shared by LF and by glyph wrap at the last column
  assign lfs_raw     = sval_t'($signed(st.scroll));
  assign lfs         = (lfs_raw > ROWS_S) ? ROWS_S : lfs_raw;
  assign feed_col_in = (c == CH_LF) ? st.col : 7'd0;

  always_comb begin
    feed_col = feed_col_in;
    feed_row = st.row;
    feed_has = 1'b0;
    feed_cmd = '0;
    if (ay < ROW_MAX) begin
      feed_row = 6'(ay + ONE_S);
      if (st.scroll == '0) begin
        feed_has = 1'b1;
        feed_cmd = make_cmd(CMD_DEL_CHARS, '0, COLS_S, ay + ONE_S, '0, '0, 1'b0);
      end
    end else if (st.scroll == '0) begin
      feed_row = 6'd0;
      feed_has = 1'b1;
      feed_cmd = make_cmd(CMD_DEL_CHARS, '0, COLS_S, '0, '0, '0, 1'b0);
    end else begin
      feed_has = 1'b1;
      feed_cmd = make_cmd(CMD_DEL_LINES, '0, '0, '0, lfs, '0, 1'b0);
      if (lfs != ONE_S) begin
        feed_col = 7'(clamp(sval_t'(feed_col_in), COL_MAX));
        feed_row = 6'(clamp(ay + ONE_S - lfs, ROW_MAX));
      end
    end
  end

  // Parse one character
  always_comb begin
    nxt  = st;
    cmds = '0;
    n    = '0;
    if (st.esc) begin
      case (ch)
        CH_NUL, CH_LF, CH_CR, CH_ESC, CH_DEL: begin
          // hold the pending escape
        end
        CH_LBRACKET: begin
          nxt.mode = MODE_CSI;
          nxt.esc  = 1'b0;
        end
        CH_FF: begin
          nxt.mode = MODE_ALPHA;
          nxt.esc  = 1'b0;
          nxt.col  = 7'd0;
          nxt.row  = 6'd0;
          cmds[n]  = make_cmd(CMD_CLEAR, '0, COLS_S, '0, ROWS_S, '0, 1'b0);
          n        = n + 2'd1;
        end
        default: begin
          nxt.esc = 1'b0;
        end
      endcase
    end

    if (!st.esc || ch == CH_QUERY) begin
      case (st.mode)
        MODE_CSI: begin
          if (!c[7] && c >= CH_ZERO && c <= CH_NINE) begin
            nxt.arg_cur = {{4{acc[11]}}, acc};
          end else if (c == CH_SEMI) begin
            nxt.arg_first = st.arg_cur;
            nxt.arg_cur   = '0;
          end else begin
            nxt.arg_cur = 16'(ac);
            nxt.mode    = MODE_ALPHA;
            case (c)
              CSI_ICH: begin
                cmds[n] = make_cmd(CMD_INS_CHARS, ax, ax + ac, ay, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_CUU: nxt.row = 6'(clamp(ay - ac, ROW_MAX));
              CSI_CUD: nxt.row = 6'(clamp(ay + ac, ROW_MAX));
              CSI_CUF: nxt.col = 7'(clamp(ax + ac, COL_MAX));
              CSI_CUB: nxt.col = 7'(clamp(ax - ac, COL_MAX));
              CSI_CNL: begin
                nxt.col = 7'd0;
                nxt.row = 6'(clamp(ay + ac, ROW_MAX));
              end
              CSI_CUP, CSI_HVP: begin
                if (st.arg_first[15]) begin
                  nxt.col = 7'd0;
                  nxt.row = 6'(clamp(ac - ONE_S, ROW_MAX));
                end else begin
                  nxt.col = 7'(clamp(ac - ONE_S, COL_MAX));
                  nxt.row = 6'(clamp(first - ONE_S, ROW_MAX));
                end
              end
              CSI_ED: begin
                cmds[n] = make_cmd(CMD_DEL_LINES, '0, '0, ay + ONE_S, ROWS_S, '0, 1'b0);
                n       = n + 2'd1;
                cmds[n] = make_cmd(CMD_DEL_CHARS, ax, COLS_S, ay, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_EL: begin
                cmds[n] = make_cmd(CMD_DEL_CHARS, ax, COLS_S, ay, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_IL: begin
                cmds[n] = make_cmd(CMD_INS_LINES, '0, '0, ay, ay + ac, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_DL: begin
                cmds[n] = make_cmd(CMD_DEL_LINES, '0, '0, ay, ay + ac, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_DCH: begin
                cmds[n] = make_cmd(CMD_DEL_CHARS, ax, ax + ac, ay, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              CSI_SGR: nxt.char_rev = (st.arg_cur != '0);
              CSI_POS: begin
                if (st.scr_rev) begin
                  nxt.scr_rev = 1'b0;
                  cmds[n]     = make_cmd(CMD_INVERT, '0, '0, '0, '0, '0, 1'b0);
                  n           = n + 2'd1;
                end
              end
              CSI_NEG: begin
                if (!st.scr_rev) begin
                  nxt.scr_rev = 1'b1;
                  cmds[n]     = make_cmd(CMD_INVERT, '0, '0, '0, '0, '0, 1'b0);
                  n           = n + 2'd1;
                end
              end
              CSI_SCROLL: nxt.scroll = st.arg_cur;
              CSI_FONT: begin
                cmds[n] = make_cmd(CMD_FONT_INIT, ax, '0, ay, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              default: begin
                // unknown final below '@' (high bytes included) skips the sequence
                if (c[7] || c < CH_AT) begin
                  nxt.mode = MODE_SKIP;
                end
              end
            endcase
          end
        end
        MODE_SKIP: begin
          if (!c[7] && c >= CH_AT) begin
            nxt.mode = MODE_ALPHA;
          end
        end
        default: begin
          nxt.mode      = MODE_ALPHA;
          nxt.arg_cur   = '0;
          nxt.arg_first = '1;
          case (c)
            CH_BEL: begin
              cmds[n] = make_cmd(CMD_BELL, '0, '0, '0, '0, '0, 1'b0);
              n       = n + 2'd1;
            end
            CH_BS: nxt.col = 7'(clamp(ax - ONE_S, COL_MAX));
            CH_HT: nxt.col = 7'(clamp(sval_t'({st.col[6:3], 3'b000}) + sval_t'(8), COL_MAX));
            CH_LF: begin
              nxt.col = feed_col;
              nxt.row = feed_row;
              if (feed_has) begin
                cmds[n] = feed_cmd;
                n       = n + 2'd1;
              end
            end
            CH_VT: nxt.row = 6'(clamp(ay - ONE_S, ROW_MAX));
            CH_FF: begin
              nxt.col = 7'd0;
              nxt.row = 6'd0;
              cmds[n] = make_cmd(CMD_CLEAR, '0, COLS_S, '0, ROWS_S, '0, 1'b0);
              n       = n + 2'd1;
            end
            CH_CR:  nxt.col = 7'd0;
            CH_ESC: nxt.esc = 1'b1;
            CH_DEL: begin
              // drop
            end
            default: begin
              // printable: draw, then advance or wrap with a line feed
              if (!c[7] && c >= CH_SPACE) begin
                cmds[n] = make_cmd(CMD_GLYPH, ax, '0, ay, '0,
                                   sval_t'(c) - sval_t'(CH_SPACE), st.char_rev);
                n = n + 2'd1;
                if (ax < COL_MAX) begin
                  nxt.col = st.col + 7'd1;
                end else begin
                  nxt.col = feed_col;
                  nxt.row = feed_row;
                  if (feed_has) begin
                    cmds[n] = feed_cmd;
                    n       = n + 2'd1;
                  end
                end
              end
            end
          endcase
        end
      endcase
    end
    cnt = n;
  end

endmodule

/* src/atci_out_buf.sv */
// ----------------------------------------------------------------------------
// atci_out_buf: result buffer
// Holds the commands of one character and sends them one beat per cycle
// while out_stall is low, marking the final beat of the run.
// ----------------------------------------------------------------------------
module atci_out_buf (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  atci_pkg::res_cnt_t                        load_cnt,
  input  atci_pkg::cmd_t [atci_pkg::RES_DEPTH-1:0]  load_cmds,
  output logic                                      free,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output atci_pkg::cmd_t                            out_cmd,
  output logic                                      out_last
);
  import atci_pkg::*;

  cmd_t [RES_DEPTH-1:0] slots;
  res_cnt_t             cnt;
  res_cnt_t             ptr;
  logic                 take;

  assign out_valid = (cnt != '0);
  assign out_cmd   = slots[ptr];
  assign out_last  = (ptr == 2'(cnt - 2'd1));
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && out_last);

  // Refill on a new run, advance within a run, empty after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (load && load_cnt != '0) begin
      cnt <= load_cnt;
      ptr <= '0;
    end else if (take && out_last) begin
      cnt <= '0;
      ptr <= '0;
    end else if (take) begin
      ptr <= ptr + 2'd1;
    end
  end

  // Hold payload of the run
  always_ff @(posedge clk) begin
    if (load && load_cnt != '0) begin
      slots <= load_cmds;
    end
  end

endmodule

/* src/ansi_text_console_interpreter.sv */
// ----------------------------------------------------------------------------
// ansi_text_console_interpreter: ANSI escape sequence console parser
// Takes one character beat per cycle while char_stall is low and turns it
// into zero to two console drawing commands (glyphs, clears, insert/delete
// of chars and lines, bell, polarity and font commands) with their
// coordinates. A character is registered, parsed combinationally against
// the parser state, and its commands are loaded into a result buffer that
// sends one beat per cycle while cmd_stall is low. With cmd_stall low, the
// rate is one character per cycle for plain text and control codes; a
// character with two commands holds the input until its last one is taken.
// The final beat of each run carries last_of_run.
// ----------------------------------------------------------------------------
module ansi_text_console_interpreter #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 34
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output logic [3:0] command,
  output logic [6:0] col_from,
  output logic [7:0] col_to,
  output logic [5:0] row_from,
  output logic [6:0] row_to,
  output logic [6:0] glyph_index,
  output logic       reverse_video,
  output logic       last_of_run
);
  import atci_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_char_q;
  state_t               state_q;
  state_t               state_next;
  cmd_t [RES_DEPTH-1:0] step_cmds;
  res_cnt_t             step_cnt;
  logic                 buf_free;
  logic                 fire;
  cmd_t                 head;

  // Parse the held character once the buffer can take its run
  assign fire       = in_valid_q && buf_free;
  assign char_stall = in_valid_q && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!char_stall) begin
      in_valid_q <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_char_q <= char_code;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= STATE_RESET;
    end else if (fire) begin
      state_q <= state_next;
    end
  end

  atci_step #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_step (
    .st   (state_q),
    .ch   (in_char_q),
    .nxt  (state_next),
    .cmds (step_cmds),
    .cnt  (step_cnt)
  );

  atci_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_cnt  (step_cnt),
    .load_cmds (step_cmds),
    .free      (buf_free),
    .out_valid (cmd_valid),
    .out_stall (cmd_stall),
    .out_cmd   (head),
    .out_last  (last_of_run)
  );

  assign command       = head.command;
  assign col_from      = head.col_from;
  assign col_to        = head.col_to;
  assign row_from      = head.row_from;
  assign row_to        = head.row_to;
  assign glyph_index   = head.glyph_index;
  assign reverse_video = head.reverse_video;

  // A pending escape only arises in alpha mode and keeps it
  a_esc_alpha: assert property (@(posedge clk) disable iff (rst)
    state_q.esc |-> state_q.mode == MODE_ALPHA)
    else $error("escape pending outside alpha mode");

  // Cursor stays on the screen
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    state_q.col <= 7'(SCREEN_COLS - 1) && state_q.row <= 6'(SCREEN_ROWS - 1))
    else $error("cursor off screen");

  // A parsed character with commands shows a beat next cycle
  a_run_out: assert property (@(posedge clk) disable iff (rst)
    fire && step_cnt != '0 |=> cmd_valid)
    else $error("commands of a character lost");

  // Input stalls only while a character is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> in_valid_q && cmd_valid)
    else $error("input stalled with nothing pending");

endmodule
